// ----- hdl/skn_pkg.sv -----
// Shared types and constants for the sorted key node table.
`default_nettype none
package skn_pkg;

    localparam int KEY_SLOTS  = 31;
    localparam int CHILD_BITS = 64;
    localparam int KEY_W      = 64;
    localparam int CNT_W      = $clog2(KEY_SLOTS + 1);

    typedef logic [KEY_W-1:0]      key_t;
    typedef logic [CHILD_BITS-1:0] child_t;
    typedef logic [CNT_W-1:0]      cnt_t;

    typedef enum logic [2:0] {
        OP_LOOKUP = 3'd0,
        OP_INSERT = 3'd1,
        OP_UPDATE = 3'd2,
        OP_REMOVE = 3'd3,
        OP_RELINK = 3'd4,
        OP_CLEAR  = 3'd5
    } op_t;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_NOT_FOUND   = 3'd1,
        ST_EXISTS      = 3'd2,
        ST_FULL        = 3'd3,
        ST_UNSUPPORTED = 3'd4,
        ST_INVALID     = 3'd5
    } status_t;

    localparam logic CFG_HEIGHT    = 1'b0;
    localparam logic CFG_EMPTY_KEY = 1'b1;

    // Apply-phase command broadcast to every cell.
    typedef struct packed {
        logic   ins;
        logic   rem;
        logic   upd;
        logic   rel;
        logic   clr;
        logic   leaf;
        key_t   key;
        child_t child;
        child_t alt;
    } cell_cmd_t;

    // Flags and data a cell hands to both of its neighbors.
    typedef struct packed {
        logic   valid;
        logic   lt;
        logic   le;
        logic   found;
        key_t   key;
        child_t child;
    } cell_link_t;

endpackage
`default_nettype wire

// ----- hdl/skn_cell.sv -----
// One slot of the node: key, child, valid bit and registered compare flags.
`default_nettype none
module skn_cell (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cmp_en,
    input  wire skn_pkg::key_t          cmp_key,
    input  wire skn_pkg::child_t        cmp_child,
    input  wire logic                   apply,
    input  wire skn_pkg::cell_cmd_t     cmd,
    input  wire skn_pkg::cell_link_t    left,
    input  wire skn_pkg::cell_link_t    right,
    output skn_pkg::cell_link_t         link,
    output logic                        eq,
    output logic                        ceq,
    output logic                        sel,
    output skn_pkg::child_t             sel_child
);

    skn_pkg::key_t   key_reg, key_next;
    skn_pkg::child_t child_reg, child_next;
    logic            valid_reg, valid_next;
    logic            lt_reg, eq_reg, ceq_reg;

    // Capture compares at accept; the table is stable until apply.
    always_ff @(posedge clk)
    begin
        if (cmp_en)
        begin
            lt_reg  <= valid_reg && (key_reg < cmp_key);
            eq_reg  <= valid_reg && (key_reg == cmp_key);
            ceq_reg <= valid_reg && (child_reg == cmp_child);
        end
    end

    always_comb
    begin
        key_next   = key_reg;
        child_next = child_reg;
        valid_next = valid_reg;
        if (apply)
        begin
            if (cmd.ins && !lt_reg)
            begin
                if (left.lt)
                begin
                    key_next   = cmd.key;
                    child_next = cmd.child;
                    valid_next = 1'b1;
                end
                else
                begin
                    key_next   = left.key;
                    child_next = left.child;
                    valid_next = left.valid;
                end
            end
            else if (cmd.rem && !lt_reg)
            begin
                key_next   = right.key;
                child_next = right.child;
                valid_next = right.valid;
            end
            else if (cmd.upd && eq_reg)
            begin
                child_next = cmd.child;
            end
            else if (cmd.rel && ceq_reg && !left.found)
            begin
                child_next = cmd.alt;
            end
            else if (cmd.clr)
            begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        child_reg <= child_next;
    end

    assign link.valid = valid_reg;
    assign link.lt    = lt_reg;
    assign link.le    = lt_reg | eq_reg;
    assign link.found = left.found | ceq_reg;
    assign link.key   = key_reg;
    assign link.child = child_reg;

    assign eq  = eq_reg;
    assign ceq = ceq_reg;
    // Interior lookup picks the first slot whose key is above the search key.
    assign sel = cmd.leaf ? eq_reg : (valid_reg && !(lt_reg | eq_reg) && left.le);
    assign sel_child = sel ? child_reg : '0;

endmodule
`default_nettype wire

// ----- hdl/sorted_key_node_table.sv -----
// Top level of the sorted key node table: control, counters and cell chain.
// Each operation has an accept phase and an apply phase: the accept edge registers key
// and child compares in every cell, the next edge applies the shift or rewrite across
// the chain; busy is high while applying, so no new item is accepted then. The result
// appears with a one-cycle done strobe the cycle after apply and must be taken then,
// since the receiver cannot stall.
// Configuration writes are always ready and must be made while idle.
`default_nettype none
module sorted_key_node_table (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  operation,
    input  wire logic [63:0] key,
    input  wire logic [63:0] child_ref,
    input  wire logic [63:0] alt_ref,
    output logic             done,
    output logic [2:0]       status,
    output logic [63:0]      child_out,
    output logic [4:0]       key_count,
    output logic             node_full,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [63:0] cfg_data
);

    localparam int N = skn_pkg::KEY_SLOTS;

    logic                apply_reg;
    logic                done_reg;
    logic [3:0]          height_reg;
    skn_pkg::key_t       empty_key_reg;
    skn_pkg::cnt_t       count_reg, count_next;
    skn_pkg::op_t        op_reg;
    logic                key_empty_reg;
    skn_pkg::key_t       key_reg;
    skn_pkg::child_t     ref_reg, alt_reg;
    skn_pkg::status_t    status_reg, status_next;
    skn_pkg::child_t     child_out_reg, pick;
    skn_pkg::cell_cmd_t  cmd;
    skn_pkg::cell_link_t links [N+2];
    skn_pkg::cell_link_t tail;
    logic [N-1:0]        eq_v, ceq_v, sel_v, valid_v;
    skn_pkg::child_t     sel_c [N];
    logic                accept, any_eq, any_ceq, any_sel, is_full, ok;

    assign accept    = start && !busy;
    assign busy      = apply_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            height_reg    <= 4'd1;
            empty_key_reg <= '0;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == skn_pkg::CFG_HEIGHT)
            begin
                height_reg <= cfg_data[3:0];
            end
            else
            begin
                empty_key_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg        <= skn_pkg::op_t'(operation);
            key_reg       <= key;
            key_empty_reg <= (key == empty_key_reg);
            ref_reg       <= child_ref[skn_pkg::CHILD_BITS-1:0];
            alt_reg       <= alt_ref[skn_pkg::CHILD_BITS-1:0];
        end
    end

    assign any_eq  = |eq_v;
    assign any_ceq = |ceq_v;
    assign any_sel = |sel_v;
    assign is_full = (count_reg == skn_pkg::CNT_W'(N));

    always_comb
    begin
        status_next = skn_pkg::ST_OK;
        case (op_reg)
            skn_pkg::OP_LOOKUP:
                status_next = any_sel ? skn_pkg::ST_OK : skn_pkg::ST_NOT_FOUND;
            skn_pkg::OP_INSERT:
                if (key_empty_reg)
                    status_next = skn_pkg::ST_INVALID;
                else if (is_full)
                    status_next = skn_pkg::ST_FULL;
                else if (any_eq)
                    status_next = skn_pkg::ST_EXISTS;
            skn_pkg::OP_UPDATE:
                if (key_empty_reg)
                    status_next = skn_pkg::ST_INVALID;
                else if (!any_eq)
                    status_next = skn_pkg::ST_NOT_FOUND;
            skn_pkg::OP_REMOVE:
                if (key_empty_reg)
                    status_next = skn_pkg::ST_INVALID;
                else if (height_reg != 4'd1)
                    status_next = skn_pkg::ST_UNSUPPORTED;
                else if (!any_eq)
                    status_next = skn_pkg::ST_NOT_FOUND;
            skn_pkg::OP_RELINK:
                status_next = any_ceq ? skn_pkg::ST_OK : skn_pkg::ST_NOT_FOUND;
            skn_pkg::OP_CLEAR:
                status_next = skn_pkg::ST_OK;
            default:
                status_next = skn_pkg::ST_UNSUPPORTED;
        endcase
    end

    assign ok = (status_next == skn_pkg::ST_OK);

    always_comb
    begin
        cmd.ins   = ok && (op_reg == skn_pkg::OP_INSERT);
        cmd.rem   = ok && (op_reg == skn_pkg::OP_REMOVE);
        cmd.upd   = ok && (op_reg == skn_pkg::OP_UPDATE);
        cmd.rel   = ok && (op_reg == skn_pkg::OP_RELINK);
        cmd.clr   = (op_reg == skn_pkg::OP_CLEAR);
        cmd.leaf  = (height_reg == 4'd1);
        cmd.key   = key_reg;
        cmd.child = ref_reg;
        cmd.alt   = alt_reg;
    end

    always_comb
    begin
        count_next = count_reg;
        if (apply_reg)
        begin
            if (cmd.ins)
                count_next = count_reg + 1'b1;
            else if (cmd.rem)
                count_next = count_reg - 1'b1;
            else if (cmd.clr)
                count_next = '0;
        end
    end

    always_comb
    begin
        pick = '0;
        for (int i = 0; i < N; i++)
        begin
            pick = pick | sel_c[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            apply_reg <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            apply_reg <= accept;
            done_reg  <= apply_reg;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (apply_reg)
        begin
            status_reg    <= status_next;
            child_out_reg <= (op_reg == skn_pkg::OP_LOOKUP && any_sel) ? pick : '0;
        end
    end

    // Chain ends: the head acts as a slot below every key, the tail as empty.
    always_comb
    begin
        links[0]       = '0;
        links[0].lt    = 1'b1;
        links[0].le    = 1'b1;
        links[0].found = 1'b0;
        tail           = '0;
        links[N+1]     = tail;
    end

    for (genvar i = 0; i < N; i++)
    begin : g_cell
        skn_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmp_en    (accept),
            .cmp_key   (key),
            .cmp_child (child_ref[skn_pkg::CHILD_BITS-1:0]),
            .apply     (apply_reg),
            .cmd       (cmd),
            .left      (links[i]),
            .right     (links[i+2]),
            .link      (links[i+1]),
            .eq        (eq_v[i]),
            .ceq       (ceq_v[i]),
            .sel       (sel_v[i]),
            .sel_child (sel_c[i])
        );
        assign valid_v[i] = links[i+1].valid;
    end

    assign done      = done_reg;
    assign status    = status_reg;
    assign child_out = 64'(child_out_reg);
    assign key_count = 5'(count_reg);
    assign node_full = (count_reg == skn_pkg::CNT_W'(N));

    a_apply_one: assert property (@(posedge clk) disable iff (!rst_n)
        apply_reg |=> !apply_reg && done_reg)
        else $error("apply phase longer than one cycle");
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= skn_pkg::CNT_W'(N))
        else $error("key count above capacity");
    a_count_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_v) == int'(count_reg))
        else $error("key count disagrees with valid cells");
    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(apply_reg))
        else $error("result without apply phase");

endmodule
`default_nettype wire
